// File: rtl/lbsa_pkg.sv
`default_nettype none

package lbsa_pkg;

   // Framebuffer size in pixels; coordinates never reach COORD_LIMIT.
   localparam logic [12:0] FB_WIDTH    = 13'd1920;
   localparam logic [12:0] FB_HEIGHT   = 13'd1080;
   localparam logic [12:0] COORD_LIMIT = 13'd4096;

   // The setup divider makes one quotient bit per cycle.
   localparam int          DIV_BITS = 29;
   localparam logic [4:0]  DIV_LAST = 5'(DIV_BITS - 1);

   typedef enum logic [2:0] {
      REG_DST_X       = 3'd0,
      REG_DST_Y       = 3'd1,
      REG_DST_W       = 3'd2,
      REG_DST_H       = 3'd3,
      REG_CROP_ORIGIN = 3'd4,
      REG_SRC_W       = 3'd5,
      REG_SRC_H       = 3'd6,
      REG_ZOOM        = 3'd7
   } lbsa_reg_type;

   typedef enum logic [3:0] {
      SU_IDLE,
      SU_FIT_W,
      SU_FIT_H,
      SU_SCALE,
      SU_DRAW,
      SU_OFFSET,
      SU_BOUNDS,
      SU_INV_W,
      SU_INV_H
   } lbsa_setup_state_type;

   typedef struct packed {
      logic signed [12:0] dst_x;
      logic signed [12:0] dst_y;
      logic [12:0]        dst_w;
      logic [12:0]        dst_h;
      logic [23:0]        crop_origin;
      logic [11:0]        src_w;
      logic [11:0]        src_h;
      logic [15:0]        zoom;
   } lbsa_cfg_type;

   // Geometry that the setup sequencer computes and the pixel pipeline uses.
   typedef struct packed {
      logic        active;
      logic [12:0] lo_x;
      logic [12:0] hi_x;
      logic [12:0] lo_y;
      logic [12:0] hi_y;
      logic [27:0] kx_base;
      logic [27:0] ky_off;
      logic [27:0] inv_w;
      logic [27:0] inv_h;
   } lbsa_geom_type;

endpackage

`default_nettype wire

// File: rtl/lbsa_req_if.sv
`default_nettype none

interface lbsa_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pix_x;
   logic [11:0] pix_y;

   modport source (output valid, output pix_x, output pix_y, input ready);
   modport sink   (input valid, input pix_x, input pix_y, output ready);
endinterface

`default_nettype wire

// File: rtl/lbsa_rsp_if.sv
`default_nettype none

interface lbsa_rsp_if;
   logic        valid;
   logic        ready;
   logic        covered;
   logic [12:0] src_x;
   logic [12:0] src_y;

   modport source (output valid, output covered, output src_x, output src_y, input ready);
   modport sink   (input valid, input covered, input src_x, input src_y, output ready);
endinterface

`default_nettype wire

// File: rtl/lbsa_setup.sv
`default_nettype none

module lbsa_setup (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  lbsa_pkg::lbsa_cfg_type cfg,
   output logic                   busy,
   output lbsa_pkg::lbsa_geom_type geom
);
   import lbsa_pkg::*;

   lbsa_setup_state_type state_ff, state_in;

   logic [4:0]         cnt_ff;
   logic [32:0]        rem_ff;
   logic [27:0]        quo_ff;
   logic [28:0]        fit_w_ff, fit_h_ff;
   logic [36:0]        scale_ff;
   logic [32:0]        draw_w_ff, draw_h_ff;
   logic signed [35:0] off_x_ff, off_y_ff;
   lbsa_geom_type      geom_ff;

   logic [28:0] div_num;
   logic [32:0] div_den;
   logic        div_active;
   logic        div_done;
   logic [33:0] rem_sh;
   logic        q_bit;
   logic [33:0] rem_next;
   logic [28:0] quotient;
   logic [28:0] base;
   logic [44:0] scale_prod;
   logic [48:0] draw_w_prod, draw_h_prod;

   // Offset of the drawn image inside the rectangle; the halving rounds toward zero.
   function automatic logic signed [35:0] axis_offset(input logic signed [12:0] d0,
                                                      input logic [12:0] dw,
                                                      input logic [32:0] draw);
      logic signed [35:0] diff;
      logic signed [35:0] half;
      diff = $signed({23'b0, dw}) - $signed({3'b0, draw});
      half = diff[35] ? ((diff + 36'sd1) >>> 1) : (diff >>> 1);
      return 36'(d0) + half;
   endfunction

   function automatic logic [12:0] axis_lo(input logic signed [35:0] off,
                                           input logic signed [12:0] d0);
      logic signed [35:0] m;
      m = (off > 36'sd0) ? off : 36'sd0;
      if (36'(d0) > m) begin
         m = 36'(d0);
      end
      if (m > $signed({23'b0, COORD_LIMIT})) begin
         return COORD_LIMIT;
      end
      return m[12:0];
   endfunction

   function automatic logic [12:0] axis_hi(input logic signed [35:0] off,
                                           input logic [32:0] draw,
                                           input logic signed [12:0] d0,
                                           input logic [12:0] dw,
                                           input logic [12:0] fb);
      logic signed [35:0] m;
      logic signed [35:0] draw_end;
      logic signed [35:0] rect_end;
      draw_end = off + $signed({3'b0, draw});
      rect_end = 36'(d0) + $signed({23'b0, dw});
      m = $signed({23'b0, fb});
      if (draw_end < m) begin
         m = draw_end;
      end
      if (rect_end < m) begin
         m = rect_end;
      end
      if (m < 36'sd0) begin
         return 13'd0;
      end
      return m[12:0];
   endfunction

   assign div_active = state_ff inside {SU_FIT_W, SU_FIT_H, SU_INV_W, SU_INV_H};
   assign div_done   = div_active && (cnt_ff == 5'd0);

   always_comb begin
      state_in = state_ff;
      div_num  = '0;
      div_den  = '0;
      case (state_ff)
         SU_IDLE: begin
            state_in = SU_IDLE;
         end
         SU_FIT_W: begin
            div_num = {cfg.dst_w, 16'h0};
            div_den = {21'b0, cfg.src_w};
            if (div_done) begin
               state_in = SU_FIT_H;
            end
         end
         SU_FIT_H: begin
            div_num = {cfg.dst_h, 16'h0};
            div_den = {21'b0, cfg.src_h};
            if (div_done) begin
               state_in = SU_SCALE;
            end
         end
         SU_SCALE: begin
            state_in = SU_DRAW;
         end
         SU_DRAW: begin
            state_in = SU_OFFSET;
         end
         SU_OFFSET: begin
            state_in = SU_BOUNDS;
         end
         SU_BOUNDS: begin
            state_in = SU_INV_W;
         end
         SU_INV_W: begin
            div_num = {1'b0, cfg.src_w, 16'h0};
            div_den = draw_w_ff;
            if (div_done) begin
               state_in = SU_INV_H;
            end
         end
         SU_INV_H: begin
            div_num = {1'b0, cfg.src_h, 16'h0};
            div_den = draw_h_ff;
            if (div_done) begin
               state_in = SU_IDLE;
            end
         end
         default: begin
            state_in = SU_IDLE;
         end
      endcase
      if (restart) begin
         state_in = SU_FIT_W;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SU_FIT_W;
      end else begin
         state_ff <= state_in;
      end
   end

   // Restoring division, one quotient bit per cycle, MSB first.
   assign rem_sh   = {rem_ff, div_num[cnt_ff]};
   assign q_bit    = rem_sh >= {1'b0, div_den};
   assign rem_next = q_bit ? (rem_sh - {1'b0, div_den}) : rem_sh;
   assign quotient = {quo_ff, q_bit};

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         cnt_ff <= DIV_LAST;
         rem_ff <= '0;
      end else if (div_active) begin
         if (div_done) begin
            cnt_ff <= DIV_LAST;
            rem_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff - 5'd1;
            rem_ff <= rem_next[32:0];
         end
      end
   end

   assign base        = (fit_w_ff < fit_h_ff) ? fit_w_ff : fit_h_ff;
   assign scale_prod  = 45'(base) * 45'(cfg.zoom);
   assign draw_w_prod = 49'(cfg.src_w) * 49'(scale_ff);
   assign draw_h_prod = 49'(cfg.src_h) * 49'(scale_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.active <= 1'b0;
      end else if (state_ff == SU_BOUNDS) begin
         geom_ff.active <= (cfg.src_w != 12'd0) && (cfg.src_h != 12'd0) &&
                           (draw_w_ff != 33'd0) && (draw_h_ff != 33'd0);
      end
      if (div_active) begin
         quo_ff <= quotient[27:0];
      end
      if (div_done) begin
         case (state_ff)
            SU_FIT_W: fit_w_ff      <= quotient;
            SU_FIT_H: fit_h_ff      <= quotient;
            SU_INV_W: geom_ff.inv_w <= quotient[27:0];
            SU_INV_H: geom_ff.inv_h <= quotient[27:0];
            default: begin
            end
         endcase
      end
      case (state_ff)
         SU_SCALE: begin
            scale_ff <= scale_prod[44:8];
         end
         SU_DRAW: begin
            draw_w_ff <= draw_w_prod[48:16];
            draw_h_ff <= draw_h_prod[48:16];
         end
         SU_OFFSET: begin
            off_x_ff <= axis_offset(cfg.dst_x, cfg.dst_w, draw_w_ff);
            off_y_ff <= axis_offset(cfg.dst_y, cfg.dst_h, draw_h_ff);
         end
         SU_BOUNDS: begin
            geom_ff.lo_x    <= axis_lo(off_x_ff, cfg.dst_x);
            geom_ff.lo_y    <= axis_lo(off_y_ff, cfg.dst_y);
            geom_ff.hi_x    <= axis_hi(off_x_ff, draw_w_ff, cfg.dst_x, cfg.dst_w, FB_WIDTH);
            geom_ff.hi_y    <= axis_hi(off_y_ff, draw_h_ff, cfg.dst_y, cfg.dst_h, FB_HEIGHT);
            // Only the low bits matter: a covered pixel's index stays below 2^28
            // whenever the inverse ratio is nonzero.
            geom_ff.kx_base <= draw_w_ff[27:0] - 28'd1 + off_x_ff[27:0];
            geom_ff.ky_off  <= off_y_ff[27:0];
         end
         default: begin
         end
      endcase
   end

   assign busy = state_ff != SU_IDLE;
   assign geom = geom_ff;

endmodule

`default_nettype wire

// File: rtl/letterbox_scaler_source_address_unit.sv
`default_nettype none

// Maps one framebuffer pixel per clock to the nearest-neighbor source pixel of a
// cropped image that is scaled to fit a destination rectangle, centered in it and
// clipped to the rectangle and the framebuffer; columns come out mirrored. Each
// beat passes the pipeline stages bounds check, 28x28 index multiply and crop add,
// and a new beat is taken every cycle unless setup runs, a register is written or the
// receiver holds up a full pipeline. After reset and after every register write, a
// setup sequencer recomputes the fit, scale, drawn size, bounds and inverse ratios;
// its one-bit-per-cycle divider runs four divisions, and req_ch.ready stays low throughout.
module letterbox_scaler_source_address_unit (
   input  logic        clock,
   input  logic        reset,
   lbsa_req_if.sink    req_ch,
   lbsa_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import lbsa_pkg::*;

   lbsa_cfg_type  cfg_ff;
   lbsa_geom_type geom;
   logic          setup_busy;

   logic        v1_ff, v2_ff, v3_ff;
   logic        v1_in, v2_in, v3_in;
   logic        rdy1, rdy2, rdy3;
   logic        req_acc;

   logic        cov1_in, cov1_ff, cov2_ff, cov3_ff;
   logic [27:0] kx1_in, ky1_in, kx1_ff, ky1_ff;
   logic [55:0] prod_x, prod_y;
   logic [11:0] idx_x2_ff, idx_y2_ff;
   logic [12:0] src_x3_ff, src_y3_ff;
   logic [12:0] px, py;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dst_x       <= 13'sd0;
         cfg_ff.dst_y       <= 13'sd0;
         cfg_ff.dst_w       <= 13'd1920;
         cfg_ff.dst_h       <= 13'd1080;
         cfg_ff.crop_origin <= 24'd0;
         cfg_ff.src_w       <= 12'd0;
         cfg_ff.src_h       <= 12'd0;
         cfg_ff.zoom        <= 16'd256;
      end else if (csr_we) begin
         case (lbsa_reg_type'(csr_index))
            REG_DST_X:       cfg_ff.dst_x       <= csr_wdata[12:0];
            REG_DST_Y:       cfg_ff.dst_y       <= csr_wdata[12:0];
            REG_DST_W:       cfg_ff.dst_w       <= csr_wdata[12:0];
            REG_DST_H:       cfg_ff.dst_h       <= csr_wdata[12:0];
            REG_CROP_ORIGIN: cfg_ff.crop_origin <= csr_wdata;
            REG_SRC_W:       cfg_ff.src_w       <= csr_wdata[11:0];
            REG_SRC_H:       cfg_ff.src_h       <= csr_wdata[11:0];
            REG_ZOOM:        cfg_ff.zoom        <= csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   lbsa_setup u_setup (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_we),
      .cfg     (cfg_ff),
      .busy    (setup_busy),
      .geom    (geom)
   );

   // Each stage moves on when the one after it is empty or moving.
   assign rdy3    = !v3_ff || rsp_ch.ready;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;
   assign req_ch.ready = rdy1 && !setup_busy && !csr_we;
   assign req_acc = req_ch.valid && req_ch.ready;

   assign v1_in = req_acc || (v1_ff && !rdy2);
   assign v2_in = (v1_ff && rdy2) || (v2_ff && !rdy3);
   assign v3_in = (v2_ff && rdy3) || (v3_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Stage 1: coverage test and distance into the drawn image.
   assign px      = {1'b0, req_ch.pix_x};
   assign py      = {1'b0, req_ch.pix_y};
   assign cov1_in = geom.active &&
                    (px >= geom.lo_x) && (px < geom.hi_x) &&
                    (py >= geom.lo_y) && (py < geom.hi_y);
   assign kx1_in  = geom.kx_base - {16'b0, req_ch.pix_x};
   assign ky1_in  = {16'b0, req_ch.pix_y} - geom.ky_off;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         cov1_ff <= cov1_in;
         kx1_ff  <= kx1_in;
         ky1_ff  <= ky1_in;
      end
   end

   // Stage 2: scale the distance by the inverse ratio. A covered product is below 2^28.
   assign prod_x = 56'(kx1_ff) * 56'(geom.inv_w);
   assign prod_y = 56'(ky1_ff) * 56'(geom.inv_h);

   always_ff @(posedge clock) begin
      if (rdy2) begin
         cov2_ff   <= cov1_ff;
         idx_x2_ff <= prod_x[27:16];
         idx_y2_ff <= prod_y[27:16];
      end
   end

   // Stage 3: add the crop origin; uncovered pixels report zero.
   always_ff @(posedge clock) begin
      if (rdy3) begin
         cov3_ff   <= cov2_ff;
         src_x3_ff <= cov2_ff ? ({1'b0, cfg_ff.crop_origin[11:0]} + {1'b0, idx_x2_ff})
                              : 13'd0;
         src_y3_ff <= cov2_ff ? ({1'b0, cfg_ff.crop_origin[23:12]} + {1'b0, idx_y2_ff})
                              : 13'd0;
      end
   end

   assign rsp_ch.valid   = v3_ff;
   assign rsp_ch.covered = cov3_ff;
   assign rsp_ch.src_x   = src_x3_ff;
   assign rsp_ch.src_y   = src_y3_ff;

   a_no_beat_during_setup : assert property (@(posedge clock) disable iff (reset)
      setup_busy |-> !req_ch.ready)
      else $error("request beat offered while setup is running");

   a_write_starts_setup : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> setup_busy)
      else $error("register write did not restart setup");

   a_beat_enters_pipe : assert property (@(posedge clock) disable iff (reset)
      req_acc |=> v1_ff)
      else $error("accepted beat missing from first stage");

   a_uncovered_is_zero : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !cov3_ff) |-> (src_x3_ff == 13'd0 && src_y3_ff == 13'd0))
      else $error("uncovered pixel reports a nonzero source address");

endmodule

`default_nettype wire

// File: bench/tb_letterbox_scaler_source_address_unit.sv
`default_nettype none

module tb_letterbox_scaler_source_address_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import lbsa_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int HOLD_PHASE      = 6;
   localparam int CALM_PHASE      = 4;
   localparam int PAUSE_PHASE     = 8;

   typedef struct packed {
      logic        covered;
      logic [12:0] src_x;
      logic [12:0] src_y;
   } src_pixel_type;

   typedef struct {
      bit            is_write;
      lbsa_reg_type  reg_sel;
      logic [23:0]   wdata;
      logic [11:0]   px;
      logic [11:0]   py;
      bit            fixed;
      src_pixel_type want;
   } script_row_type;

   typedef enum {
      LAY_TYPICAL,
      LAY_MAX,
      LAY_ONE_PIXEL,
      LAY_FAR_CORNER,
      LAY_ANY
   } layout_kind_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [23:0] csr_wdata;

   lbsa_req_if req_ch();
   lbsa_rsp_if rsp_ch();

   letterbox_scaler_source_address_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lbsa_cfg_type   layout;
   src_pixel_type  pending_src_q[$];
   script_row_type script[$];
   int             mismatch_count = 0;
   int             cycle_count = 0;
   int             rsp_gap;
   bit             calm = 1'b0;
   bit             hold_go = 1'b0;
   logic           hold_active;

   layout_kind_type phase_kind [PHASES] = '{
      LAY_TYPICAL, LAY_MAX, LAY_TYPICAL, LAY_ONE_PIXEL, LAY_TYPICAL, LAY_FAR_CORNER,
      LAY_TYPICAL, LAY_ANY, LAY_TYPICAL, LAY_ANY, LAY_TYPICAL, LAY_TYPICAL
   };

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One axis of the letterbox: clip against the centered drawing, the
   // rectangle and the framebuffer, then map to a source index.
   function automatic bit map_axis(input longint pos, input longint d0, input longint extent,
                                   input longint drawn, input longint srcn, input longint fb,
                                   input bit mirror, output longint idx);
      longint off, lo, hi, inv, k;
      idx = 0;
      off = d0 + (extent - drawn) / 2;
      lo = (off > d0) ? off : d0;
      lo = (lo > 0) ? lo : 0;
      hi = (off + drawn < d0 + extent) ? off + drawn : d0 + extent;
      hi = (hi < fb) ? hi : fb;
      if (pos < lo || pos >= hi) return 1'b0;
      inv = (srcn << 16) / drawn;
      k = pos - off;
      if (mirror) k = drawn - 1 - k;
      idx = (k * inv) >> 16;
      return 1'b1;
   endfunction

   function automatic src_pixel_type source_pixel_for(input logic [11:0] px,
                                                      input logic [11:0] py);
      longint sw, sh, dw, dh, zm, dx0, dy0;
      longint fit_w, fit_h, base, scale, draw_w, draw_h, sx, sy, sum;
      src_pixel_type r;
      r = '0;
      sw = longint'(layout.src_w);
      sh = longint'(layout.src_h);
      dw = longint'(layout.dst_w);
      dh = longint'(layout.dst_h);
      zm = longint'(layout.zoom);
      dx0 = longint'(layout.dst_x);
      dy0 = longint'(layout.dst_y);
      if (sw == 0 || sh == 0) return r;
      fit_w = (dw << 16) / sw;
      fit_h = (dh << 16) / sh;
      base = (fit_w < fit_h) ? fit_w : fit_h;
      scale = (base * zm) >> 8;
      draw_w = (sw * scale) >> 16;
      draw_h = (sh * scale) >> 16;
      if (draw_w == 0 || draw_h == 0) return r;
      if (!map_axis(longint'(px), dx0, dw, draw_w, sw, longint'(FB_WIDTH), 1'b1, sx)) return r;
      if (!map_axis(longint'(py), dy0, dh, draw_h, sh, longint'(FB_HEIGHT), 1'b0, sy)) return r;
      r.covered = 1'b1;
      sum = longint'(layout.crop_origin[11:0]) + sx;
      r.src_x = sum[12:0];
      sum = longint'(layout.crop_origin[23:12]) + sy;
      r.src_y = sum[12:0];
      return r;
   endfunction

   function automatic script_row_type w_row(input lbsa_reg_type sel, input logic [23:0] data);
      script_row_type r;
      r = '{reg_sel: REG_DST_X, default: '0};
      r.is_write = 1'b1;
      r.reg_sel = sel;
      r.wdata = data;
      return r;
   endfunction

   function automatic script_row_type p_row(input int px, input int py);
      script_row_type r;
      r = '{reg_sel: REG_DST_X, default: '0};
      r.px = 12'(px);
      r.py = 12'(py);
      return r;
   endfunction

   function automatic script_row_type f_row(input int px, input int py, input bit cov,
                                            input int sx, input int sy);
      script_row_type r;
      r = p_row(px, py);
      r.fixed = 1'b1;
      r.want.covered = cov;
      r.want.src_x = 13'(sx);
      r.want.src_y = 13'(sy);
      return r;
   endfunction

   function automatic int draw_gap();
      return calm ? 0 : int'($urandom_range(0, 11));
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // Only the register's own width is kept, as in the block.
   task automatic write_csr(input lbsa_reg_type sel, input logic [23:0] data);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      case (sel)
         REG_DST_X:       layout.dst_x = data[12:0];
         REG_DST_Y:       layout.dst_y = data[12:0];
         REG_DST_W:       layout.dst_w = data[12:0];
         REG_DST_H:       layout.dst_h = data[12:0];
         REG_CROP_ORIGIN: layout.crop_origin = data;
         REG_SRC_W:       layout.src_w = data[11:0];
         REG_SRC_H:       layout.src_h = data[11:0];
         REG_ZOOM:        layout.zoom = data[15:0];
         default: ;
      endcase
   endtask

   // Sometimes fills the bits above the register width with noise.
   task automatic write_field(input lbsa_reg_type sel, input int value, input int width);
      logic [23:0] word;
      word = 24'(value);
      if (width < 24) begin
         word = word & ((24'd1 << width) - 24'd1);
         if ($urandom_range(0, 2) == 0) word = word | 24'($urandom << width);
      end
      write_csr(sel, word);
   endtask

   task automatic apply_layout(input layout_kind_type kind);
      int dx, dy, dw, dh, sw, sh, zm, crop;
      crop = $urandom;
      case (kind)
         LAY_MAX: begin
            dx = -4096; dy = -4096; dw = 8191; dh = 8191;
            sw = 4095; sh = 4095; zm = 65535; crop = 24'hFFFFFF;
         end
         LAY_ONE_PIXEL: begin
            dx = 0; dy = 0; dw = 1; dh = 1; sw = 1; sh = 1; zm = 256;
         end
         LAY_FAR_CORNER: begin
            dx = 4095; dy = 4095; dw = 0; dh = 0; sw = 1; sh = 1; zm = 256;
         end
         LAY_ANY: begin
            dx = $urandom; dy = $urandom;
            dw = $urandom_range(0, 8191); dh = $urandom_range(0, 8191);
            sw = $urandom_range(0, 4095); sh = $urandom_range(0, 4095);
            zm = $urandom_range(0, 65535);
         end
         default: begin
            dx = int'($urandom_range(0, 2400)) - 400;
            dy = int'($urandom_range(0, 1500)) - 300;
            dw = $urandom_range(1, 2600);
            dh = $urandom_range(1, 1600);
            sw = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 4095);
            sh = $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 4095);
            case ($urandom_range(0, 3))
               0, 1:    zm = 256;
               2:       zm = $urandom_range(64, 1024);
               default: zm = $urandom_range(0, 65535);
            endcase
         end
      endcase
      write_field(REG_DST_X, dx, 13);
      write_field(REG_DST_Y, dy, 13);
      write_field(REG_DST_W, dw, 13);
      write_field(REG_DST_H, dh, 13);
      write_field(REG_CROP_ORIGIN, crop, 24);
      write_field(REG_SRC_W, sw, 12);
      write_field(REG_SRC_H, sh, 12);
      write_field(REG_ZOOM, zm, 16);
      csr_we <= 1'b0;
   endtask

   // Aims a share of the pixels at the destination edges, where clipping happens.
   task automatic pick_pixel(output logic [11:0] px, output logic [11:0] py);
      int sel, ex, ey;
      sel = $urandom_range(0, 9);
      if (sel < 4) begin
         px = 12'($urandom);
         py = 12'($urandom);
      end else if (sel < 8) begin
         px = 12'($urandom_range(0, 1919));
         py = 12'($urandom_range(0, 1079));
      end else begin
         ex = int'(layout.dst_x);
         ey = int'(layout.dst_y);
         if ($urandom_range(0, 1)) ex += int'(layout.dst_w);
         if ($urandom_range(0, 1)) ey += int'(layout.dst_h);
         ex += int'($urandom_range(0, 8)) - 4;
         ey += int'($urandom_range(0, 8)) - 4;
         px = 12'((ex < 0) ? 0 : (ex > 4095) ? 4095 : ex);
         py = 12'((ey < 0) ? 0 : (ey > 4095) ? 4095 : ey);
      end
   endtask

   task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                             input bit fixed, input src_pixel_type want);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pix_x <= px;
      req_ch.pix_y <= py;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      pending_src_q.push_back(fixed ? want : source_pixel_for(px, py));
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_src_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver: a fresh wait is drawn after every beat it takes.
   always @(posedge clock) begin : drive_rsp_ready
      int wait_cycles;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_gap <= 0;
      end else if (hold_active) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.ready === 1'b1 && rsp_ch.valid === 1'b1) begin
         wait_cycles = draw_gap();
         rsp_gap <= wait_cycles;
         rsp_ch.ready <= (wait_cycles == 0);
      end else if (rsp_gap != 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ch.ready <= (rsp_gap == 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      hold_active <= 1'b0;
      wait (hold_go);
      @(posedge clock);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin : watch_rsp
      src_pixel_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_src_q.size() == 0) begin
            flag_mismatch("result beat with nothing pending, covered",
                          int'(rsp_ch.covered), 0);
         end else begin
            want = pending_src_q.pop_front();
            if (rsp_ch.covered !== want.covered)
               flag_mismatch("covered", int'(rsp_ch.covered), int'(want.covered));
            if (rsp_ch.src_x !== want.src_x)
               flag_mismatch("src_x", int'(rsp_ch.src_x), int'(want.src_x));
            if (rsp_ch.src_y !== want.src_y)
               flag_mismatch("src_y", int'(rsp_ch.src_y), int'(want.src_y));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [11:0] px, py;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= REG_DST_X;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.pix_x <= '0;
      req_ch.pix_y <= '0;
      layout = '0;
      layout.dst_w = 13'd1920;
      layout.dst_h = 13'd1080;
      layout.zoom = 16'd256;

      // An empty source covers nothing.
      script.push_back(f_row(0, 0, 0, 0, 0));
      script.push_back(f_row(4095, 4095, 0, 0, 0));
      // One to one over the whole framebuffer; columns come out mirrored.
      script.push_back(w_row(REG_SRC_W, 24'd1920));
      script.push_back(w_row(REG_SRC_H, 24'd1080));
      script.push_back(f_row(0, 0, 1, 1919, 0));
      script.push_back(f_row(1919, 1079, 1, 0, 1079));
      script.push_back(f_row(1920, 0, 0, 0, 0));
      script.push_back(f_row(0, 1080, 0, 0, 0));
      script.push_back(f_row(4095, 4095, 0, 0, 0));
      script.push_back(w_row(REG_CROP_ORIGIN, 24'h005007));
      script.push_back(f_row(0, 0, 1, 1926, 5));
      script.push_back(w_row(REG_CROP_ORIGIN, 24'hFFFFFF));
      script.push_back(f_row(1919, 1079, 1, 4095, 5174));
      script.push_back(f_row(0, 0, 1, 6014, 4095));
      // A zero zoom draws nothing; the largest zoom is clipped to the framebuffer.
      script.push_back(w_row(REG_ZOOM, 24'd0));
      script.push_back(f_row(960, 540, 0, 0, 0));
      script.push_back(w_row(REG_ZOOM, 24'd65535));
      script.push_back(p_row(0, 0));
      script.push_back(p_row(1919, 1079));
      script.push_back(p_row(960, 540));
      // Half size leaves a border on every side.
      script.push_back(w_row(REG_ZOOM, 24'd128));
      script.push_back(p_row(480, 270));
      script.push_back(p_row(479, 269));
      script.push_back(p_row(1439, 809));
      // A one pixel wide rectangle for a wide source rounds the drawing to nothing.
      script.push_back(w_row(REG_ZOOM, 24'd256));
      script.push_back(w_row(REG_SRC_W, 24'd4095));
      script.push_back(w_row(REG_DST_W, 24'd1));
      script.push_back(f_row(0, 0, 0, 0, 0));
      // Noise above the register width must be dropped.
      script.push_back(w_row(REG_DST_X, 24'hFFF000));
      script.push_back(w_row(REG_DST_W, 24'hFFFFFF));
      script.push_back(w_row(REG_SRC_W, 24'd1920));
      script.push_back(p_row(0, 0));
      script.push_back(p_row(4095, 0));
      script.push_back(p_row(1919, 1079));
      script.push_back(w_row(REG_DST_Y, 24'h000FFF));
      script.push_back(f_row(0, 0, 0, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < script.size(); i++) begin
         if (script[i].is_write) begin
            if (i == 0 || !script[i - 1].is_write) drain_results();
            write_csr(script[i].reg_sel, script[i].wdata);
            if (i + 1 == script.size() || !script[i + 1].is_write) csr_we <= 1'b0;
         end else begin
            send_pixel(script[i].px, script[i].py, script[i].fixed, script[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain_results();
         apply_layout(phase_kind[ph]);
         calm = (ph == CALM_PHASE || ph == HOLD_PHASE);
         // The receiver stalls for a long stretch while beats keep coming.
         if (ph == HOLD_PHASE) hold_go = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2) drain_results();
            pick_pixel(px, py);
            send_pixel(px, py, 1'b0, '0);
         end
      end
      drain_results();

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
